// ----- rtl/isv_pkg.sv -----
// Shared types and constants for the ISBN string validator.
`timescale 1ns / 1ps

package isv_pkg;

   localparam int CHAR_W  = 8;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 6;
   localparam int DIGIT_W = 4;

   // ASCII codes of interest
   localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_DASH    = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_X_UPPER = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_X_LOWER = 8'h78;

   // separator occurrence window
   localparam logic [COUNT_W-1:0] SEP_MIN = 6'd3;
   localparam logic [COUNT_W-1:0] SEP_MAX = 6'd4;

   // stripped lengths
   localparam logic [COUNT_W-1:0] ISBN10_LEN = 6'd10;
   localparam logic [COUNT_W-1:0] ISBN13_LEN = 6'd13;
   localparam logic [COUNT_W-1:0] TENTH_IDX  = 6'd9;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 6'd63;

   localparam logic [DIGIT_W-1:0] X_VALUE = 4'd10;

   // x mod 11 for x < 128: q = (x * 187) >> 11
   localparam logic [7:0] RECIP11       = 8'd187;
   localparam int         RECIP11_SHIFT = 11;
   localparam logic [3:0] MOD11         = 4'd11;

   typedef enum logic [KIND_W-1:0] {
      KIND_NONE   = 2'd0,
      KIND_ISBN10 = 2'd1,
      KIND_ISBN13 = 2'd2
   } kind_type;

endpackage

// ----- rtl/isv_ifs.sv -----
// Request and response channel interfaces of the ISBN string validator.
`timescale 1ns / 1ps

interface isv_req_if;
   logic                       valid;
   logic                       ready;
   logic [isv_pkg::CHAR_W-1:0] char_code;
   logic                       is_last;

   modport source (output valid, char_code, is_last, input ready);
   modport sink   (input valid, char_code, is_last, output ready);
endinterface

interface isv_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       format_ok;
   logic [isv_pkg::KIND_W-1:0] isbn_kind;
   logic                       checksum_ok;

   modport source (output valid, format_ok, isbn_kind, checksum_ok, input ready);
   modport sink   (input valid, format_ok, isbn_kind, checksum_ok, output ready);
endinterface

// ----- rtl/isbn_string_validator.sv -----
// Top level of the ISBN-10 / ISBN-13 string validator.
`timescale 1ns / 1ps

// Usage:
//  req_if carries one ASCII character per request, is_last marks the end of
//  a string. rsp_if returns one response per string: format_ok, isbn_kind
//  (0 none, 1 ISBN-10, 2 ISBN-13) and checksum_ok.
//  Characters are taken one per cycle while req_if.ready is high. Each request
//  is captured in an input register. A non-last character is processed in the
//  following cycle into the running state; the last character goes into the
//  response register once no earlier response is held there. Sustained rate:
//  one character per cycle while no response is held stalled, set by the
//  single state update between input and response registers.
//  When rsp_if stalls, characters keep flowing until a second last character
//  reaches the input register; it then waits there and req_if.ready drops
//  until the held response is taken.
//  Strings longer than MAX_CHARS report format_ok = 0. After each string
//  the state returns to its reset value.
//  Reset (synchronous) empties both registers and clears all counters and
//  sums; no clearing pass is needed.
module isbn_string_validator #(
   parameter int MAX_CHARS = 32
) (
   input  logic      clock,
   input  logic      reset,
   isv_req_if.sink   req_if,
   isv_rsp_if.source rsp_if
);

   localparam int CCW = $clog2(MAX_CHARS + 1);
   localparam int CW  = isv_pkg::COUNT_W;

   // input register
   logic                       s1_valid_ff, s1_valid_in;
   logic [isv_pkg::CHAR_W-1:0] s1_char_ff;
   logic                       s1_last_ff;

   // running string state
   logic [isv_pkg::CHAR_W-1:0] previous_char_ff, previous_char_in;
   logic [CW-1:0]              space_count_ff, space_count_in;
   logic [CW-1:0]              dash_count_ff, dash_count_in;
   logic                       space_doubled_ff, space_doubled_in;
   logic                       dash_doubled_ff, dash_doubled_in;
   logic                       bad_character_ff, bad_character_in;
   logic [CW-1:0]              digit_count_ff, digit_count_in;
   logic [3:0]                 sum_mod_eleven_ff, sum_mod_eleven_in;
   logic [3:0]                 sum_mod_ten_ff, sum_mod_ten_in;
   logic                       misplaced_x_ff, misplaced_x_in;
   logic                       tenth_x_ff, tenth_x_in;
   logic [CCW-1:0]             char_count_ff, char_count_in;

   // response register
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       format_ok_ff, format_ok_in;
   isv_pkg::kind_type          kind_ff, kind_in;
   logic                       checksum_ok_ff, checksum_ok_in;

   // update values before the end-of-string clear
   logic [CW-1:0]              space_count_upd, dash_count_upd, digit_count_upd;
   logic                       space_doubled_upd, dash_doubled_upd, bad_character_upd;
   logic [3:0]                 sum_mod_eleven_upd, sum_mod_ten_upd;
   logic                       misplaced_x_upd, tenth_x_upd;

   logic                       advance, finish;
   logic                       overlong, is_space, is_dash, is_digit, is_x;
   logic [isv_pkg::CHAR_W-1:0] c;
   logic [3:0]                 digit_val, w11;
   logic [6:0]                 prod11, acc11, rem11;
   logic [14:0]                recip_prod;
   logic [3:0]                 quot11;
   logic [4:0]                 prod10;
   logic [5:0]                 acc10;
   logic                       space_pass, dash_pass, fmt;

   function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
      return (v < isv_pkg::COUNT_MAX) ? v + 1'b1 : v;
   endfunction

   function automatic logic sep_pass(input logic [CW-1:0] cnt, input logic dbl);
      return !dbl && cnt >= isv_pkg::SEP_MIN && cnt <= isv_pkg::SEP_MAX;
   endfunction

   // handshake: a non-last character never waits on the response side
   assign advance = s1_valid_ff && (!s1_last_ff || !rsp_valid_ff || rsp_if.ready);
   assign finish  = advance && s1_last_ff;
   assign req_if.ready = !s1_valid_ff || advance;

   assign s1_valid_in = (req_if.valid && req_if.ready) ? 1'b1 :
                        (advance ? 1'b0 : s1_valid_ff);

   // character classes
   assign c        = s1_char_ff;
   assign overlong = char_count_ff >= CCW'(MAX_CHARS);
   assign is_space = c == isv_pkg::CHAR_SPACE;
   assign is_dash  = c == isv_pkg::CHAR_DASH;
   assign is_digit = c >= isv_pkg::CHAR_ZERO && c <= isv_pkg::CHAR_NINE;
   assign is_x     = c == isv_pkg::CHAR_X_UPPER || c == isv_pkg::CHAR_X_LOWER;
   assign digit_val = is_digit ? c[3:0] : isv_pkg::X_VALUE;

   // weighted sum mod 11, weight = position + 1 (only positions 0..9 used)
   assign w11        = digit_count_ff[3:0] + 4'd1;
   assign prod11     = 7'(digit_val * w11);
   assign acc11      = 7'(sum_mod_eleven_ff) + prod11;
   assign recip_prod = 15'(acc11 * isv_pkg::RECIP11);
   assign quot11     = 4'(recip_prod >> isv_pkg::RECIP11_SHIFT);
   assign rem11      = acc11 - 7'(quot11 * isv_pkg::MOD11);

   // alternating 1/3 sum mod 10
   assign prod10 = digit_count_ff[0] ? 5'(digit_val * 4'd3) : 5'(digit_val);
   assign acc10  = 6'(sum_mod_ten_ff) + 6'(prod10);

   always_comb begin
      space_count_upd    = space_count_ff;
      dash_count_upd     = dash_count_ff;
      digit_count_upd    = digit_count_ff;
      space_doubled_upd  = space_doubled_ff;
      dash_doubled_upd   = dash_doubled_ff;
      bad_character_upd  = bad_character_ff;
      sum_mod_eleven_upd = sum_mod_eleven_ff;
      sum_mod_ten_upd    = sum_mod_ten_ff;
      misplaced_x_upd    = misplaced_x_ff;
      tenth_x_upd        = tenth_x_ff;
      if (is_space) begin
         // previous_char is zero at string start, so no first-char test needed
         if (previous_char_ff == isv_pkg::CHAR_SPACE) space_doubled_upd = 1'b1;
         if (!s1_last_ff) space_count_upd = sat_inc(space_count_ff);
      end else if (is_dash) begin
         if (previous_char_ff == isv_pkg::CHAR_DASH) dash_doubled_upd = 1'b1;
         if (!s1_last_ff) dash_count_upd = sat_inc(dash_count_ff);
      end else if (is_digit || is_x) begin
         if (is_x) begin
            if (digit_count_ff == isv_pkg::TENTH_IDX) tenth_x_upd = 1'b1;
            else misplaced_x_upd = 1'b1;
         end
         if (digit_count_ff < isv_pkg::ISBN10_LEN) sum_mod_eleven_upd = rem11[3:0];
         if (digit_count_ff < isv_pkg::ISBN13_LEN && is_digit) begin
            if (acc10 >= 6'd30)      sum_mod_ten_upd = 4'(acc10 - 6'd30);
            else if (acc10 >= 6'd20) sum_mod_ten_upd = 4'(acc10 - 6'd20);
            else if (acc10 >= 6'd10) sum_mod_ten_upd = 4'(acc10 - 6'd10);
            else                     sum_mod_ten_upd = acc10[3:0];
         end
         digit_count_upd = sat_inc(digit_count_ff);
      end else begin
         bad_character_upd = 1'b1;
      end
   end

   // end-of-string verdict, from the state including this character
   assign space_pass = sep_pass(space_count_upd, space_doubled_upd);
   assign dash_pass  = sep_pass(dash_count_upd, dash_doubled_upd);
   assign fmt        = !overlong && !bad_character_upd && (space_pass || dash_pass);

   always_comb begin
      kind_in        = isv_pkg::KIND_NONE;
      checksum_ok_in = 1'b0;
      format_ok_in   = fmt;
      if (fmt) begin
         if (digit_count_upd == isv_pkg::ISBN10_LEN) begin
            kind_in        = isv_pkg::KIND_ISBN10;
            checksum_ok_in = sum_mod_eleven_upd == 4'd0 && !misplaced_x_upd;
         end else if (digit_count_upd == isv_pkg::ISBN13_LEN) begin
            kind_in        = isv_pkg::KIND_ISBN13;
            checksum_ok_in = sum_mod_ten_upd == 4'd0 && !misplaced_x_upd && !tenth_x_upd;
         end
      end
   end

   // next state: cleared after the last character of a string
   always_comb begin
      previous_char_in  = previous_char_ff;
      space_count_in    = space_count_ff;
      dash_count_in     = dash_count_ff;
      space_doubled_in  = space_doubled_ff;
      dash_doubled_in   = dash_doubled_ff;
      bad_character_in  = bad_character_ff;
      digit_count_in    = digit_count_ff;
      sum_mod_eleven_in = sum_mod_eleven_ff;
      sum_mod_ten_in    = sum_mod_ten_ff;
      misplaced_x_in    = misplaced_x_ff;
      tenth_x_in        = tenth_x_ff;
      char_count_in     = char_count_ff;
      if (finish) begin
         previous_char_in  = '0;
         space_count_in    = '0;
         dash_count_in     = '0;
         space_doubled_in  = 1'b0;
         dash_doubled_in   = 1'b0;
         bad_character_in  = 1'b0;
         digit_count_in    = '0;
         sum_mod_eleven_in = '0;
         sum_mod_ten_in    = '0;
         misplaced_x_in    = 1'b0;
         tenth_x_in        = 1'b0;
         char_count_in     = '0;
      end else if (advance) begin
         previous_char_in  = c;
         space_count_in    = space_count_upd;
         dash_count_in     = dash_count_upd;
         space_doubled_in  = space_doubled_upd;
         dash_doubled_in   = dash_doubled_upd;
         bad_character_in  = bad_character_upd;
         digit_count_in    = digit_count_upd;
         sum_mod_eleven_in = sum_mod_eleven_upd;
         sum_mod_ten_in    = sum_mod_ten_upd;
         misplaced_x_in    = misplaced_x_upd;
         tenth_x_in        = tenth_x_upd;
         char_count_in     = overlong ? char_count_ff : char_count_ff + 1'b1;
      end
   end

   assign rsp_valid_in = finish ? 1'b1 : (rsp_if.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         previous_char_ff  <= '0;
         space_count_ff    <= '0;
         dash_count_ff     <= '0;
         space_doubled_ff  <= 1'b0;
         dash_doubled_ff   <= 1'b0;
         bad_character_ff  <= 1'b0;
         digit_count_ff    <= '0;
         sum_mod_eleven_ff <= '0;
         sum_mod_ten_ff    <= '0;
         misplaced_x_ff    <= 1'b0;
         tenth_x_ff        <= 1'b0;
         char_count_ff     <= '0;
      end else begin
         s1_valid_ff       <= s1_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         previous_char_ff  <= previous_char_in;
         space_count_ff    <= space_count_in;
         dash_count_ff     <= dash_count_in;
         space_doubled_ff  <= space_doubled_in;
         dash_doubled_ff   <= dash_doubled_in;
         bad_character_ff  <= bad_character_in;
         digit_count_ff    <= digit_count_in;
         sum_mod_eleven_ff <= sum_mod_eleven_in;
         sum_mod_ten_ff    <= sum_mod_ten_in;
         misplaced_x_ff    <= misplaced_x_in;
         tenth_x_ff        <= tenth_x_in;
         char_count_ff     <= char_count_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         s1_char_ff <= req_if.char_code;
         s1_last_ff <= req_if.is_last;
      end
      if (finish) begin
         format_ok_ff   <= format_ok_in;
         kind_ff        <= kind_in;
         checksum_ok_ff <= checksum_ok_in;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.format_ok   = format_ok_ff;
   assign rsp_if.isbn_kind   = kind_ff;
   assign rsp_if.checksum_ok = checksum_ok_ff;

endmodule

// ----- rtl/isv_checker.sv -----
// Port-level assertions for the ISBN string validator, bound to the top level.
`timescale 1ns / 1ps

module isv_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic                       rsp_format_ok,
   input logic [isv_pkg::KIND_W-1:0] rsp_isbn_kind,
   input logic                       rsp_checksum_ok
);

   // no response survives a reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // a passing checksum needs a good format and a known kind
   a_checksum_implies: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_checksum_ok |->
         rsp_format_ok && rsp_isbn_kind != isv_pkg::KIND_NONE)
      else $error("checksum_ok without format or kind");

   // a failed format never reports a kind
   a_bad_format_no_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_format_ok |-> rsp_isbn_kind == isv_pkg::KIND_NONE)
      else $error("kind reported on bad format");

   // stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_format_ok) &&
         $stable(rsp_isbn_kind) && $stable(rsp_checksum_ok))
      else $error("response changed while stalled");

endmodule

bind isbn_string_validator isv_checker u_isv_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_if.valid),
   .rsp_ready       (rsp_if.ready),
   .rsp_format_ok   (rsp_if.format_ok),
   .rsp_isbn_kind   (rsp_if.isbn_kind),
   .rsp_checksum_ok (rsp_if.checksum_ok)
);

// ----- test/isbn_string_validator_test.sv -----
// Self-checking testbench for the ISBN string validator: directed strings, then random ones.
`timescale 1ns / 1ps

module isbn_string_validator_test;

   localparam int CHAR_W  = isv_pkg::CHAR_W;
   localparam int COUNT_W = isv_pkg::COUNT_W;
   localparam int DIGIT_W = isv_pkg::DIGIT_W;

   localparam int MAX_LEN      = 32;    // longest string the block accepts
   localparam int RANDOM_ITEMS = 1640;  // characters sent in the random part
   localparam int CALM_TAIL    = 300;   // last characters sent with no idling
   localparam int STALL_LIMIT  = 1000;  // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 8;     // cycles waited after the last owed verdict is checked
   localparam int DIR_ROWS     = 19;

   // One response: what the block reports for a finished string.
   typedef struct packed {
      logic              format_ok;
      isv_pkg::kind_type kind;
      logic              checksum_ok;
   } verdict_type;

   localparam verdict_type REJECT = '{format_ok: 1'b0, kind: isv_pkg::KIND_NONE,
                                      checksum_ok: 1'b0};

   // Running state of the string scan, cleared after every last character.
   typedef struct packed {
      logic [CHAR_W-1:0]  last_char;
      logic [COUNT_W-1:0] spaces;
      logic [COUNT_W-1:0] dashes;
      logic               space_twice;
      logic               dash_twice;
      logic               illegal_char;
      logic [COUNT_W-1:0] symbols;
      logic [DIGIT_W-1:0] wsum11;
      logic [DIGIT_W-1:0] asum10;
      logic               stray_x;
      logic               x_at_tenth;
      logic [COUNT_W-1:0] chars;
   } scan_state_type;

   // Directed rows either carry a typed-in verdict or are left to the predictor.
   typedef struct packed {
      logic        typed;
      verdict_type want;
   } dir_check_type;

   localparam dir_check_type PREDICTED = '{typed: 1'b0, want: REJECT};
   localparam dir_check_type REJECTED  = '{typed: 1'b1, want: REJECT};
   localparam dir_check_type NO_KIND   = '{typed: 1'b1,
                                           want: '{format_ok: 1'b1,
                                                   kind: isv_pkg::KIND_NONE,
                                                   checksum_ok: 1'b0}};

   // Directed strings; row N of dir_text goes with row N of dir_check.
   string dir_text [DIR_ROWS] = '{
      "0-306-40615-2",                              //  0 good ISBN-10, dashes
      "978-0-306-40615-7",                          //  1 good ISBN-13, four dashes
      "0 8044 2957 X",                              //  2 X as tenth digit, spaces
      "0-8044-2957-x",                              //  3 lowercase x as tenth digit
      "X-306-40615-2",                              //  4 X in first place
      "978-0-306-40615-X",                          //  5 X inside an ISBN-13
      "978 0 306 40615 8",                          //  6 bad ISBN-13 check digit
      "0-306-40615-3",                              //  7 bad ISBN-10 check digit
      "0-306-40615-2-",                             //  8 trailing dash is not counted
      "0306406152",                                 //  9 no separators
      "0--306-40615-2",                             // 10 doubled dash
      "0-306-4O615-2",                              // 11 letter O for zero
      "0-3-0-6-40615-2",                            // 12 five dashes
      "0 306-40615 2",                              // 13 mixed, neither side passes
      "\377",                                       // 14 lone top code
      "12-34-56-7",                                 // 15 well formed, wrong length
      "1234567-1234567-1234567-12345678",           // 16 exactly the length limit
      "1234567-1234567-1234567-123456789",          // 17 one past the limit
      "978-0-306-40615-7-978-0-306-40615-7-9780"    // 18 far too long
   };

   dir_check_type dir_check [DIR_ROWS] = '{
      PREDICTED, PREDICTED, PREDICTED, PREDICTED, PREDICTED,
      PREDICTED, PREDICTED, PREDICTED, PREDICTED, REJECTED,
      REJECTED,  REJECTED,  REJECTED,  REJECTED,  REJECTED,
      NO_KIND,   NO_KIND,   REJECTED,  REJECTED
   };

   logic clock = 1'b0;
   logic reset;

   isv_req_if req_bus ();
   isv_rsp_if rsp_bus ();

   isbn_string_validator #(
      .MAX_CHARS(MAX_LEN)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   scan_state_type    scan;
   verdict_type       pending_verdicts [$];   // verdicts still owed by the block
   logic [CHAR_W-1:0] isbn_chars [$];         // string being sent
   logic              req_idle;               // sender may insert gaps
   logic              rsp_idle;               // receiver may stall
   logic              typed_on;               // directed row with a typed verdict
   verdict_type       typed_want;
   int                error_count = 0;
   int                quiet_cycles = 0;

   function automatic logic sep_pass(input logic [COUNT_W-1:0] count, input logic twice);
      return !twice && count >= isv_pkg::SEP_MIN && count <= isv_pkg::SEP_MAX;
   endfunction

   // Advance the scan by one accepted request; returns 1 when a verdict is due.
   function automatic logic scan_request(input logic [CHAR_W-1:0] c, input logic last,
                                         output verdict_type v);
      logic overlong, digit, xmark, first, fmt;
      int   value, idx;
      overlong = scan.chars >= MAX_LEN;
      digit    = c >= isv_pkg::CHAR_ZERO && c <= isv_pkg::CHAR_NINE;
      xmark    = c == isv_pkg::CHAR_X_UPPER || c == isv_pkg::CHAR_X_LOWER;
      first    = scan.chars == 0;
      v        = REJECT;
      if (!overlong) scan.chars++;
      if (c == isv_pkg::CHAR_SPACE) begin
         if (!first && scan.last_char == isv_pkg::CHAR_SPACE) scan.space_twice = 1'b1;
         // the final character never counts as a separator
         if (!last && scan.spaces != isv_pkg::COUNT_MAX) scan.spaces++;
      end else if (c == isv_pkg::CHAR_DASH) begin
         if (!first && scan.last_char == isv_pkg::CHAR_DASH) scan.dash_twice = 1'b1;
         if (!last && scan.dashes != isv_pkg::COUNT_MAX) scan.dashes++;
      end else if (digit || xmark) begin
         idx   = scan.symbols;
         value = digit ? int'(c - isv_pkg::CHAR_ZERO) : int'(isv_pkg::X_VALUE);
         if (xmark) begin
            if (idx == isv_pkg::TENTH_IDX) scan.x_at_tenth = 1'b1;
            else scan.stray_x = 1'b1;
         end
         // ISBN-10: weights 1..10, mod 11; ISBN-13: weights 1,3,1,3.., mod 10
         if (idx < isv_pkg::ISBN10_LEN) begin
            scan.wsum11 = DIGIT_W'((scan.wsum11 + value * (idx + 1)) % 11);
         end
         if (idx < isv_pkg::ISBN13_LEN && digit) begin
            scan.asum10 = DIGIT_W'((scan.asum10 + value * ((idx % 2) ? 3 : 1)) % 10);
         end
         if (scan.symbols != isv_pkg::COUNT_MAX) scan.symbols++;
      end else begin
         scan.illegal_char = 1'b1;
      end
      scan.last_char = c;
      if (!last) return 1'b0;

      fmt = !overlong && !scan.illegal_char &&
            (sep_pass(scan.spaces, scan.space_twice) ||
             sep_pass(scan.dashes, scan.dash_twice));
      v.format_ok = fmt;
      if (fmt && scan.symbols == isv_pkg::ISBN10_LEN) begin
         v.kind        = isv_pkg::KIND_ISBN10;
         v.checksum_ok = scan.wsum11 == 0 && !scan.stray_x;
      end else if (fmt && scan.symbols == isv_pkg::ISBN13_LEN) begin
         v.kind        = isv_pkg::KIND_ISBN13;
         v.checksum_ok = scan.asum10 == 0 && !scan.stray_x && !scan.x_at_tenth;
      end
      scan = '0;
      return 1'b1;
   endfunction

   // Mostly legal symbols, with a fair share of arbitrary bytes.
   function automatic logic [CHAR_W-1:0] pick_char();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return CHAR_W'(isv_pkg::CHAR_ZERO + $urandom_range(0, 9));
         4:          return isv_pkg::CHAR_SPACE;
         5:          return isv_pkg::CHAR_DASH;
         6:          return $urandom_range(0, 1) ? isv_pkg::CHAR_X_UPPER
                                                 : isv_pkg::CHAR_X_LOWER;
         default:    return CHAR_W'($urandom_range(0, 255));
      endcase
   endfunction

   // Build a well-formed ISBN with random digits and grouping; now and then the
   // check digit, an X or the separator count is spoiled on purpose.
   task automatic make_isbn(input logic thirteen);
      int                n, sum, nsep, count, pos;
      int                vals [13];
      logic              gap [13];
      logic [CHAR_W-1:0] sep, other;
      n   = thirteen ? 13 : 10;
      sum = 0;
      for (int i = 0; i < n - 1; i++) begin
         vals[i] = $urandom_range(0, 9);
         sum += thirteen ? vals[i] * ((i % 2) ? 3 : 1) : vals[i] * (i + 1);
      end
      // 10 * v == -v mod 11, so the ISBN-10 check digit is the sum itself
      vals[n-1] = thirteen ? (10 - sum % 10) % 10 : sum % 11;
      if ($urandom_range(0, 3) == 0) vals[n-1] = $urandom_range(0, 10);
      if ($urandom_range(0, 9) == 0) vals[$urandom_range(0, n - 2)] = 10;
      nsep = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 6) : $urandom_range(3, 4);
      if (nsep > n - 1) nsep = n - 1;
      foreach (gap[i]) gap[i] = 1'b0;
      count = 0;
      while (count < nsep) begin
         pos = $urandom_range(0, n - 2);
         if (!gap[pos]) begin
            gap[pos] = 1'b1;
            count++;
         end
      end
      sep   = $urandom_range(0, 1) ? isv_pkg::CHAR_DASH : isv_pkg::CHAR_SPACE;
      other = (sep == isv_pkg::CHAR_DASH) ? isv_pkg::CHAR_SPACE : isv_pkg::CHAR_DASH;
      for (int i = 0; i < n; i++) begin
         if (vals[i] == 10) begin
            isbn_chars.push_back($urandom_range(0, 1) ? isv_pkg::CHAR_X_UPPER
                                                      : isv_pkg::CHAR_X_LOWER);
         end else begin
            isbn_chars.push_back(CHAR_W'(isv_pkg::CHAR_ZERO + vals[i]));
         end
         if (i < n - 1 && gap[i]) begin
            isbn_chars.push_back(($urandom_range(0, 11) == 0) ? other : sep);
         end
      end
      // trailing separator: legal, and not part of the count
      if ($urandom_range(0, 9) == 0) isbn_chars.push_back(sep);
   endtask

   task automatic build_random_text();
      int                pick, n, pos;
      logic [CHAR_W-1:0] fill;
      pick = $urandom_range(0, 99);
      isbn_chars.delete();
      if (pick < 70) begin
         make_isbn(pick >= 35);
      end else if (pick < 80) begin
         // broken sequence: one symbol replaced or doubled
         make_isbn(pick[0]);
         pos = $urandom_range(0, isbn_chars.size() - 1);
         if ($urandom_range(0, 1)) isbn_chars[pos] = pick_char();
         else isbn_chars.insert(pos, isbn_chars[pos]);
      end else if (pick < 92) begin
         n = $urandom_range(1, 20);
         repeat (n) isbn_chars.push_back(pick_char());
      end else if (pick < 98) begin
         // around the length limit
         n = $urandom_range(MAX_LEN - 4, MAX_LEN + 6);
         repeat (n) isbn_chars.push_back(pick_char());
      end else begin
         // long runs that drive the counters into saturation
         case ($urandom_range(0, 2))
            0:       fill = isv_pkg::CHAR_SPACE;
            1:       fill = isv_pkg::CHAR_DASH;
            default: fill = CHAR_W'(isv_pkg::CHAR_ZERO + $urandom_range(0, 9));
         endcase
         n = $urandom_range(64, 70);
         repeat (n) isbn_chars.push_back(fill);
      end
   endtask

   // Offer one request and hold it until taken. Valid stays high into the
   // next request unless a gap is inserted first.
   task automatic push_request(input logic [CHAR_W-1:0] c, input logic last);
      verdict_type v;
      if (req_idle && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.char_code <= c;
      req_bus.is_last   <= last;
      do @(posedge clock); while (!req_bus.ready);
      if (scan_request(c, last, v)) pending_verdicts.push_back(typed_on ? typed_want : v);
   endtask

   task automatic send_text();
      foreach (isbn_chars[i]) push_request(isbn_chars[i], i == isbn_chars.size() - 1);
   endtask

   task automatic report_mismatch(input string why, input verdict_type want,
                                  input verdict_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s: expected fmt=%0b kind=%0d sum=%0b, got fmt=%0b kind=%0d sum=%0b",
                  $time, why, want.format_ok, want.kind, want.checksum_ok,
                  got.format_ok, got.kind, got.checksum_ok);
      end
   endtask

   // Stimulus: reset, directed rows, random strings, then drain.
   initial begin
      int random_items;
      reset             <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.char_code <= '0;
      req_bus.is_last   <= 1'b0;
      req_idle     = 1'b1;
      rsp_idle     = 1'b1;
      typed_on     = 1'b0;
      typed_want   = REJECT;
      scan         = '0;
      random_items = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         isbn_chars.delete();
         for (int i = 0; i < dir_text[r].len(); i++) isbn_chars.push_back(dir_text[r][i]);
         typed_on   = dir_check[r].typed;
         typed_want = dir_check[r].want;
         send_text();
      end
      typed_on = 1'b0;

      // random part; some strings run without gaps, the tail runs flat out
      while (random_items < RANDOM_ITEMS) begin
         if (random_items >= RANDOM_ITEMS - CALM_TAIL) begin
            req_idle = 1'b0;
            rsp_idle = 1'b0;
         end else begin
            req_idle = $urandom_range(0, 4) != 0;
            rsp_idle = $urandom_range(0, 4) != 0;
         end
         build_random_text();
         send_text();
         random_items += isbn_chars.size();
      end
      req_bus.valid <= 1'b0;

      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Response side: ready drops in bursts while stalls are allowed.
   initial begin
      int stall;
      stall = 0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            if (stall == 0) rsp_bus.ready <= 1'b1;
         end else if (rsp_idle && $urandom_range(0, 7) == 0) begin
            rsp_bus.ready <= 1'b0;
            stall = $urandom_range(1, 18);
         end
      end
   end

   // Every response taken is compared with the oldest verdict owed.
   always @(posedge clock) begin
      verdict_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.format_ok   = rsp_bus.format_ok;
         got.kind        = isv_pkg::kind_type'(rsp_bus.isbn_kind);
         got.checksum_ok = rsp_bus.checksum_ok;
         if (pending_verdicts.size() == 0) begin
            report_mismatch("response with no string pending", REJECT, got);
         end else begin
            want = pending_verdicts.pop_front();
            if (got.format_ok !== want.format_ok || got.kind !== want.kind ||
                got.checksum_ok !== want.checksum_ok) begin
               report_mismatch("response mismatch", want, got);
            end
         end
      end
   end

   // Watchdog: too long without any handshake on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
